/* rtl/spre_pkg.sv */
package spre_pkg;

  // field widths
  localparam int unsigned IdxW     = 20;
  localparam int unsigned ShareW   = 5;
  localparam int unsigned CoordW   = 24;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned KW       = 16;
  localparam int unsigned CutW     = 52;
  localparam int unsigned D2W      = 52;
  localparam int unsigned SumW     = 64;
  localparam int unsigned GradW    = 40;
  localparam int unsigned CurvW    = 20;
  localparam int unsigned EnergyW  = 63;
  localparam int unsigned MisW     = 25;
  localparam int unsigned CfgDataW = 52;

  // arithmetic constants
  localparam int unsigned MaxShare  = 16;
  localparam int unsigned MinShare  = 2;
  localparam int unsigned KFracBits = 8;

  // shared multiplier operand width (signed)
  localparam int unsigned MulW = 33;

  // square root unit
  localparam int unsigned SqrtInW  = D2W;
  localparam int unsigned SqrtOutW = SqrtInW / 2;
  localparam int unsigned SqrtCntW = $clog2(SqrtOutW);
  localparam int unsigned RemW     = SqrtOutW + 2;

  // reset values of the configuration registers
  localparam logic [KW-1:0]  SpringKRst  = 16'd2560;
  localparam logic [CutW-1:0] CutoffSqRst = 52'd16777216;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSpringK  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCutoffSq = 1'd1;

endpackage

/* rtl/spre_isqrt.sv */
module spre_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [spre_pkg::SqrtInW-1:0]   value_i,
  output logic                           done_o,
  output logic [spre_pkg::SqrtOutW-1:0]  root_o
);
  import spre_pkg::*;

  logic [SqrtInW-1:0]  val_q;
  logic [RemW-1:0]     rem_q;
  logic [SqrtOutW-1:0] root_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [RemW+1:0] rem_next;
  logic [RemW+1:0] trial;
  logic            take;

  // one result bit per cycle, restoring form
  assign rem_next = {rem_q, val_q[SqrtInW-1 -: 2]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign take     = (rem_next >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == SqrtCntW'(SqrtOutW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[SqrtInW-3:0], 2'b00};
      if (take) begin
        rem_q  <= RemW'(rem_next - trial);
        root_q <= {root_q[SqrtOutW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(rem_next);
        root_q <= {root_q[SqrtOutW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/shared_point_restraint_eval.sv */
// Items are handled one at a time: in_stall_o stays high from acceptance until
//   the result goes to the output register; an item marked last_of_pass also
//   waits for the root of the largest squared distance, found one bit per cycle
//   alongside the energy products. Every product goes in turn through the
//   single shared 33x33 multiplier.
// Reset: asynchronous, active low; registers take their defaults, sums clear.
module shared_point_restraint_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [spre_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [spre_pkg::CfgDataW-1:0]    cfg_data_i,
  // input item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [spre_pkg::IdxW-1:0]        point_index_i,
  input  logic [spre_pkg::IdxW-1:0]        unit_point_index_i,
  input  logic [spre_pkg::ShareW-1:0]      share_count_i,
  input  logic signed [spre_pkg::CoordW-1:0] mean_x_i,
  input  logic signed [spre_pkg::CoordW-1:0] mean_y_i,
  input  logic signed [spre_pkg::CoordW-1:0] mean_z_i,
  input  logic signed [spre_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [spre_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [spre_pkg::CoordW-1:0] pos_z_i,
  input  logic                             last_of_pass_i,
  // result item channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [spre_pkg::IdxW-1:0]        out_unit_point_o,
  output logic signed [spre_pkg::GradW-1:0] grad_x_o,
  output logic signed [spre_pkg::GradW-1:0] grad_y_o,
  output logic signed [spre_pkg::GradW-1:0] grad_z_o,
  output logic [spre_pkg::CurvW-1:0]       curvature_o,
  output logic                             violates_o,
  output logic                             pass_done_o,
  output logic [spre_pkg::EnergyW-1:0]     energy_total_o,
  output logic [spre_pkg::MisW-1:0]        max_mismatch_o,
  output logic [spre_pkg::IdxW-1:0]        worst_point_o
);
  import spre_pkg::*;

  // One state per multiplier issue, plus states that join, sum, wait or hand off;
  // a state after an issuing state consumes the product that state issued.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,   // issue dx*dx
    ST_SQ_Y,   // issue dy*dy, take dx^2
    ST_SQ_Z,   // issue dz*dz, add dy^2
    ST_KN,     // issue k*n, add dz^2
    ST_CURV,   // issue k*(n-1), take k*n
    ST_GX,     // issue dx*kn, take curvature, cutoff compare
    ST_GY,     // issue dy*kn, round grad x
    ST_GZ,     // issue dz*kn, round grad y
    ST_WLO,    // issue low half of d2 times n, round grad z
    ST_WHI,    // issue high half of d2 times n, take low part
    ST_WSUM,   // join the two halves into n*d2
    ST_ACC,    // saturating pass sum, running maximum
    ST_ELO,    // issue k*sum[31:0], start the square root
    ST_EHI,    // issue k*sum[63:32], take low product
    ST_EADD,   // join, scale and saturate the energy
    ST_ROOT,   // wait for the square root
    ST_OUT     // hand the result to the output register
  } state_e;

  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned EShift = KFracBits + 1;
  localparam int unsigned EProdW = SumW + KW;
  localparam int unsigned WHalf = D2W / 2;
  localparam int unsigned WW = 56;

  state_e state_q;

  // configuration
  logic [KW-1:0]   k_q;
  logic [CutW-1:0] cutoff_q;

  // pass state
  logic [SumW-1:0] sum_q;
  logic [D2W-1:0]  max_q;
  logic [IdxW-1:0] maxpt_q;

  // item scratch
  logic [IdxW-1:0]         pidx_q;
  logic [IdxW-1:0]         uidx_q;
  logic [ShareW-1:0]       n_q;
  logic                    last_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic [D2W-1:0]          d2_q;
  logic [CurvW-1:0]        kn_q;
  logic [CurvW-1:0]        curv_q;
  logic                    viol_q;
  logic signed [GradW-1:0] gx_q, gy_q, gz_q;
  logic [WHalf+ShareW-1:0] wlo_q;
  logic [WW-1:0]           w_q;
  logic [2*KW+16-1:0]      elo_q;
  logic [EnergyW-1:0]      energy_q;

  // shared multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_q;

  logic                    accept;
  logic                    out_free;
  logic [ShareW-1:0]       n_clamp;
  logic [SumW:0]           sum_add;
  logic [EProdW-1:0]       eprod;
  logic                    sqrt_done;
  logic [SqrtOutW-1:0]     sqrt_root;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // clamp the share count into [2, MaxShare]
  always_comb begin
    if (share_count_i < ShareW'(MinShare)) begin
      n_clamp = ShareW'(MinShare);
    end else if (share_count_i > ShareW'(MaxShare)) begin
      n_clamp = ShareW'(MaxShare);
    end else begin
      n_clamp = share_count_i;
    end
  end

  // round the Q.20 product to nearest, ties up, into Q.12; always fits
  function automatic logic signed [GradW-1:0] round_grad(input logic signed [ProdW-1:0] p);
    logic signed [46:0] r;
    r = $signed(p[46:0]) + $signed(47'(1) << (KFracBits - 1));
    return GradW'($signed(r[46:KFracBits]));
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    case (state_q)
      ST_SQ_X: begin
        mul_a = MulW'(dx_q);
        mul_b = MulW'(dx_q);
      end
      ST_SQ_Y: begin
        mul_a = MulW'(dy_q);
        mul_b = MulW'(dy_q);
      end
      ST_SQ_Z: begin
        mul_a = MulW'(dz_q);
        mul_b = MulW'(dz_q);
      end
      ST_KN: begin
        mul_a = $signed({{(MulW-KW){1'b0}}, k_q});
        mul_b = $signed({{(MulW-ShareW){1'b0}}, n_q});
      end
      ST_CURV: begin
        mul_a = $signed({{(MulW-KW){1'b0}}, k_q});
        mul_b = $signed({{(MulW-ShareW){1'b0}}, ShareW'(n_q - 1'b1)});
      end
      ST_GX: begin
        mul_a = MulW'(dx_q);
        mul_b = $signed({{(MulW-CurvW){1'b0}}, kn_q});
      end
      ST_GY: begin
        mul_a = MulW'(dy_q);
        mul_b = $signed({{(MulW-CurvW){1'b0}}, kn_q});
      end
      ST_GZ: begin
        mul_a = MulW'(dz_q);
        mul_b = $signed({{(MulW-CurvW){1'b0}}, kn_q});
      end
      ST_WLO: begin
        mul_a = $signed({{(MulW-WHalf){1'b0}}, d2_q[WHalf-1:0]});
        mul_b = $signed({{(MulW-ShareW){1'b0}}, n_q});
      end
      ST_WHI: begin
        mul_a = $signed({{(MulW-WHalf){1'b0}}, d2_q[D2W-1:WHalf]});
        mul_b = $signed({{(MulW-ShareW){1'b0}}, n_q});
      end
      ST_ELO: begin
        mul_a = $signed({1'b0, sum_q[31:0]});
        mul_b = $signed({{(MulW-KW){1'b0}}, k_q});
      end
      ST_EHI: begin
        mul_a = $signed({1'b0, sum_q[63:32]});
        mul_b = $signed({{(MulW-KW){1'b0}}, k_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating pass sum and the joined energy product
  assign sum_add = {1'b0, sum_q} + (SumW+1)'(w_q);
  assign eprod   = {prod_q[47:0], 32'd0} + EProdW'(elo_q);

  spre_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_ELO),
    .value_i (max_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // datapath scratch: no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pidx_q <= point_index_i;
          uidx_q <= unit_point_index_i;
          n_q    <= n_clamp;
          last_q <= last_of_pass_i;
          dx_q   <= DiffW'(pos_x_i) - DiffW'(mean_x_i);
          dy_q   <= DiffW'(pos_y_i) - DiffW'(mean_y_i);
          dz_q   <= DiffW'(pos_z_i) - DiffW'(mean_z_i);
        end
      end
      ST_SQ_Y: d2_q <= prod_q[D2W-1:0];
      ST_SQ_Z: d2_q <= d2_q + prod_q[D2W-1:0];
      ST_KN:   d2_q <= d2_q + prod_q[D2W-1:0];
      ST_CURV: kn_q <= prod_q[CurvW-1:0];
      ST_GX: begin
        curv_q <= prod_q[CurvW-1:0];
        viol_q <= (d2_q > cutoff_q);
      end
      ST_GY:   gx_q <= round_grad(prod_q);
      ST_GZ:   gy_q <= round_grad(prod_q);
      ST_WLO:  gz_q <= round_grad(prod_q);
      ST_WHI:  wlo_q <= prod_q[WHalf+ShareW-1:0];
      ST_WSUM: w_q <= {prod_q[WW-WHalf-1:0], {WHalf{1'b0}}} + WW'(wlo_q);
      ST_EHI:  elo_q <= prod_q[47:0];
      ST_EADD: begin
        if (|eprod[EProdW-1:EnergyW+EShift]) begin
          energy_q <= '1;
        end else begin
          energy_q <= eprod[EnergyW+EShift-1:EShift];
        end
      end
      default: ;
    endcase
  end

  // sequencer, configuration, pass state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      k_q              <= SpringKRst;
      cutoff_q         <= CutoffSqRst;
      sum_q            <= '0;
      max_q            <= '0;
      maxpt_q          <= '0;
      out_valid_o      <= 1'b0;
      out_unit_point_o <= '0;
      grad_x_o         <= '0;
      grad_y_o         <= '0;
      grad_z_o         <= '0;
      curvature_o      <= '0;
      violates_o       <= 1'b0;
      pass_done_o      <= 1'b0;
      energy_total_o   <= '0;
      max_mismatch_o   <= '0;
      worst_point_o    <= '0;
    end else begin
      // drop the result once taken; the hand-off state refills it itself
      if (out_valid_o && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSpringK:  k_q      <= cfg_data_i[KW-1:0];
          CfgCutoffSq: cutoff_q <= cfg_data_i[CutW-1:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_SQ_X;
        end
        ST_SQ_X: state_q <= ST_SQ_Y;
        ST_SQ_Y: state_q <= ST_SQ_Z;
        ST_SQ_Z: state_q <= ST_KN;
        ST_KN:   state_q <= ST_CURV;
        ST_CURV: state_q <= ST_GX;
        ST_GX:   state_q <= ST_GY;
        ST_GY:   state_q <= ST_GZ;
        ST_GZ:   state_q <= ST_WLO;
        ST_WLO:  state_q <= ST_WHI;
        ST_WHI:  state_q <= ST_WSUM;
        ST_WSUM: state_q <= ST_ACC;
        ST_ACC: begin
          sum_q <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
          // only a strictly larger distance takes over the maximum
          if (d2_q > max_q) begin
            max_q   <= d2_q;
            maxpt_q <= pidx_q;
          end
          state_q <= last_q ? ST_ELO : ST_OUT;
        end
        ST_ELO:  state_q <= ST_EHI;
        ST_EHI:  state_q <= ST_EADD;
        ST_EADD: state_q <= ST_ROOT;
        ST_ROOT: begin
          if (sqrt_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_o      <= 1'b1;
            out_unit_point_o <= uidx_q;
            grad_x_o         <= gx_q;
            grad_y_o         <= gy_q;
            grad_z_o         <= gz_q;
            curvature_o      <= curv_q;
            violates_o       <= viol_q;
            pass_done_o      <= last_q;
            if (last_q) begin
              energy_total_o <= energy_q;
              max_mismatch_o <= sqrt_root[MisW-1:0];
              worst_point_o  <= maxpt_q;
              sum_q          <= '0;
              max_q          <= '0;
              maxpt_q        <= '0;
            end else begin
              energy_total_o <= '0;
              max_mismatch_o <= '0;
              worst_point_o  <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // an accepted item starts the multiply sequence on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SQ_X))
    else $error("accepted item did not start the sequence");

  // a new result only comes from the hand-off state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the hand-off state");

  // totals are zero on results that do not close a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pass_done_o) |->
      (energy_total_o == '0 && max_mismatch_o == '0 && worst_point_o == '0))
    else $error("pass totals on an item not marked last");

endmodule

/* tb/sv/restraint_result_check.sv */
`timescale 1ns / 100ps
module restraint_result_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spre_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [spre_pkg::IdxW-1:0]     point_index_i,
  input  logic [spre_pkg::IdxW-1:0]     unit_point_index_i,
  input  logic [spre_pkg::ShareW-1:0]   share_count_i,
  input  logic [spre_pkg::CoordW-1:0]   mean_x_i,
  input  logic [spre_pkg::CoordW-1:0]   mean_y_i,
  input  logic [spre_pkg::CoordW-1:0]   mean_z_i,
  input  logic [spre_pkg::CoordW-1:0]   pos_x_i,
  input  logic [spre_pkg::CoordW-1:0]   pos_y_i,
  input  logic [spre_pkg::CoordW-1:0]   pos_z_i,
  input  logic                          last_of_pass_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [spre_pkg::IdxW-1:0]     out_unit_point_i,
  input  logic [spre_pkg::GradW-1:0]    grad_x_i,
  input  logic [spre_pkg::GradW-1:0]    grad_y_i,
  input  logic [spre_pkg::GradW-1:0]    grad_z_i,
  input  logic [spre_pkg::CurvW-1:0]    curvature_i,
  input  logic                          violates_i,
  input  logic                          pass_done_i,
  input  logic [spre_pkg::EnergyW-1:0]  energy_total_i,
  input  logic [spre_pkg::MisW-1:0]     max_mismatch_i,
  input  logic [spre_pkg::IdxW-1:0]     worst_point_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import spre_pkg::*;

  typedef struct {
    logic [IdxW-1:0]    unit;
    logic [GradW-1:0]   gx;
    logic [GradW-1:0]   gy;
    logic [GradW-1:0]   gz;
    logic [CurvW-1:0]   curv;
    logic               viol;
    logic               done;
    logic [EnergyW-1:0] energy;
    logic [MisW-1:0]    mis;
    logic [IdxW-1:0]    worst;
  } restraint_result_t;

  localparam longint GradLimit = (longint'(1) << (GradW - 1)) - 1;

  logic [KW-1:0]     spring_k;
  logic [CutW-1:0]   cutoff_sq;
  logic [SumW-1:0]   weighted_dist_sum;
  logic [D2W-1:0]    peak_dist_sq;
  logic [IdxW-1:0]   peak_point;

  restraint_result_t expected_results[$];
  int mismatches = 0;
  int backlog = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  // round half up from Q.20 into Q.12, then clamp to the gradient range
  function automatic logic [GradW-1:0] scaled_gradient(longint diff, longint kn);
    longint g;
    g = (diff * kn + (longint'(1) << (KFracBits - 1))) >>> KFracBits;
    if (g > GradLimit) g = GradLimit;
    if (g < -GradLimit - 1) g = -GradLimit - 1;
    return g[GradW-1:0];
  endfunction

  // largest r with r*r <= v, built one bit at a time from the top
  function automatic logic [MisW-1:0] floor_root(logic [D2W-1:0] v);
    logic [26:0] r;
    logic [26:0] t;
    r = '0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (27'd1 << b);
      if (64'(t) * 64'(t) <= 64'(v)) r = t;
    end
    return r[MisW-1:0];
  endfunction

  // work out the result of the item on the input ports and advance the pass sums
  function automatic restraint_result_t predict_restraint();
    restraint_result_t r;
    longint n;
    longint kn;
    longint dx;
    longint dy;
    longint dz;
    logic [63:0] d2;
    logic [63:0] curv;
    logic [SumW:0] acc;
    logic [SumW+KW-1:0] kprod;
    n = longint'(share_count_i);
    if (n < MinShare) n = MinShare;
    if (n > MaxShare) n = MaxShare;
    dx = longint'($signed(pos_x_i)) - longint'($signed(mean_x_i));
    dy = longint'($signed(pos_y_i)) - longint'($signed(mean_y_i));
    dz = longint'($signed(pos_z_i)) - longint'($signed(mean_z_i));
    d2 = dx * dx + dy * dy + dz * dz;
    kn = longint'(spring_k) * n;
    curv = longint'(spring_k) * (n - 1);
    if (curv > {CurvW{1'b1}}) curv = {CurvW{1'b1}};

    r.unit = unit_point_index_i;
    r.gx   = scaled_gradient(dx, kn);
    r.gy   = scaled_gradient(dy, kn);
    r.gz   = scaled_gradient(dz, kn);
    r.curv = curv[CurvW-1:0];
    r.viol = d2 > cutoff_sq;
    r.done = last_of_pass_i;
    r.energy = '0;
    r.mis    = '0;
    r.worst  = '0;

    acc = weighted_dist_sum + d2 * 64'(n);
    weighted_dist_sum = acc[SumW] ? '1 : acc[SumW-1:0];
    if (d2 > peak_dist_sq) begin
      peak_dist_sq = d2[D2W-1:0];
      peak_point   = point_index_i;
    end

    if (last_of_pass_i) begin
      kprod = weighted_dist_sum * spring_k;
      r.energy = (|kprod[SumW+KW-1:EnergyW+KFracBits+1]) ? '1 :
                 kprod[EnergyW+KFracBits:KFracBits+1];
      r.mis   = floor_root(peak_dist_sq);
      r.worst = peak_point;
      weighted_dist_sum = '0;
      peak_dist_sq      = '0;
      peak_point        = '0;
    end
    return r;
  endfunction

  // append one predicted result behind those already waiting
  task automatic queue_expected(restraint_result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    restraint_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      spring_k          = SpringKRst;
      cutoff_sq         = CutoffSqRst;
      weighted_dist_sum = '0;
      peak_dist_sq      = '0;
      peak_point        = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result item for unit %h arrived with none expected",
                   $time, out_unit_point_i);
        end else begin
          want = expected_results.pop_front();
          compare_field("out_unit_point", 64'(want.unit), 64'(out_unit_point_i));
          compare_field("grad_x", 64'(want.gx), 64'(grad_x_i));
          compare_field("grad_y", 64'(want.gy), 64'(grad_y_i));
          compare_field("grad_z", 64'(want.gz), 64'(grad_z_i));
          compare_field("curvature", 64'(want.curv), 64'(curvature_i));
          compare_field("violates", 64'(want.viol), 64'(violates_i));
          compare_field("pass_done", 64'(want.done), 64'(pass_done_i));
          compare_field("energy_total", 64'(want.energy), 64'(energy_total_i));
          compare_field("max_mismatch", 64'(want.mis), 64'(max_mismatch_i));
          compare_field("worst_point", 64'(want.worst), 64'(worst_point_i));
        end
      end
      // an item taken at the same edge as a write is predicted with the old setting
      if (in_valid_i && !in_stall_i) queue_expected(predict_restraint());
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSpringK:  spring_k  = cfg_data_i[KW-1:0];
          CfgCutoffSq: cutoff_sq = cfg_data_i[CutW-1:0];
          default: ;
        endcase
      end
    end
    backlog = expected_results.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
  import spre_pkg::*;

  // one input item as the driver sees it
  typedef struct {
    logic [IdxW-1:0]   point;
    logic [IdxW-1:0]   unit;
    logic [ShareW-1:0] share;
    logic [CoordW-1:0] mx;
    logic [CoordW-1:0] my;
    logic [CoordW-1:0] mz;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] pz;
    logic              last;
  } restraint_item_t;

  // how the coordinates of a random item are spread
  typedef enum int {
    ShapeScatter,   // anywhere in the Q12.12 range
    ShapeNear,      // copy close to the mean, around the default cutoff
    ShapeCorner,    // coordinates at or next to the range ends
    ShapeFar        // opposite corners with the share count at its top
  } item_shape_e;

  localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW - 1){1'b0}}};
  localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW - 1){1'b1}}};

  localparam int PhaseItems  = 25;
  // maximal items needed to push the pass sum into its ceiling, with margin
  localparam int FloodItems  = 1450;
  // the wait before the verdict outlasts the handling of a last item, root included
  localparam int DrainCycles = 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [IdxW-1:0]     point_index;
  logic [IdxW-1:0]     unit_point_index;
  logic [ShareW-1:0]   share_count;
  logic [CoordW-1:0]   mean_x;
  logic [CoordW-1:0]   mean_y;
  logic [CoordW-1:0]   mean_z;
  logic [CoordW-1:0]   pos_x;
  logic [CoordW-1:0]   pos_y;
  logic [CoordW-1:0]   pos_z;
  logic                last_of_pass;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IdxW-1:0]     out_unit_point;
  logic [GradW-1:0]    grad_x;
  logic [GradW-1:0]    grad_y;
  logic [GradW-1:0]    grad_z;
  logic [CurvW-1:0]    curvature;
  logic                violates;
  logic                pass_done;
  logic [EnergyW-1:0]  energy_total;
  logic [MisW-1:0]     max_mismatch;
  logic [IdxW-1:0]     worst_point;

  int fail_count;
  int pending;
  // high while neither side may idle
  bit calm = 1'b0;

  shared_point_restraint_eval uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .point_index_i      (point_index),
    .unit_point_index_i (unit_point_index),
    .share_count_i      (share_count),
    .mean_x_i           (mean_x),
    .mean_y_i           (mean_y),
    .mean_z_i           (mean_z),
    .pos_x_i            (pos_x),
    .pos_y_i            (pos_y),
    .pos_z_i            (pos_z),
    .last_of_pass_i     (last_of_pass),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_unit_point_o   (out_unit_point),
    .grad_x_o           (grad_x),
    .grad_y_o           (grad_y),
    .grad_z_o           (grad_z),
    .curvature_o        (curvature),
    .violates_o         (violates),
    .pass_done_o        (pass_done),
    .energy_total_o     (energy_total),
    .max_mismatch_o     (max_mismatch),
    .worst_point_o      (worst_point)
  );

  // watch both channels, predict each result and compare it
  restraint_result_check result_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .point_index_i      (point_index),
    .unit_point_index_i (unit_point_index),
    .share_count_i      (share_count),
    .mean_x_i           (mean_x),
    .mean_y_i           (mean_y),
    .mean_z_i           (mean_z),
    .pos_x_i            (pos_x),
    .pos_y_i            (pos_y),
    .pos_z_i            (pos_z),
    .last_of_pass_i     (last_of_pass),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .out_unit_point_i   (out_unit_point),
    .grad_x_i           (grad_x),
    .grad_y_i           (grad_y),
    .grad_z_i           (grad_z),
    .curvature_i        (curvature),
    .violates_i         (violates),
    .pass_done_i        (pass_done),
    .energy_total_i     (energy_total),
    .max_mismatch_i     (max_mismatch),
    .worst_point_i      (worst_point),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always #1 clk = ~clk;

  // stall the result side now and then, never during the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  // bound the run; a hang ends here
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic restraint_item_t restraint_item(
    logic [IdxW-1:0] point, logic [IdxW-1:0] unit, logic [ShareW-1:0] share,
    logic [CoordW-1:0] mx, logic [CoordW-1:0] my, logic [CoordW-1:0] mz,
    logic [CoordW-1:0] px, logic [CoordW-1:0] py, logic [CoordW-1:0] pz,
    logic last);
    restraint_item_t it;
    it.point = point;
    it.unit  = unit;
    it.share = share;
    it.mx    = mx;
    it.my    = my;
    it.mz    = mz;
    it.px    = px;
    it.py    = py;
    it.pz    = pz;
    it.last  = last;
    return it;
  endfunction

  // move a coordinate by a signed offset of random magnitude, wrapping in range
  function automatic logic [CoordW-1:0] nudged(logic [CoordW-1:0] base);
    int unsigned span;
    span = $urandom_range(1, 15);
    return base + CoordW'($urandom_range(0, (1 << span) - 1)) - CoordW'(1 << (span - 1));
  endfunction

  function automatic logic [CoordW-1:0] corner_coord();
    case ($urandom_range(5))
      0: return CoordMin;
      1: return CoordMax;
      2: return '0;
      3: return '1;
      4: return CoordMin + CoordW'($urandom_range(3));
      default: return CoordW'($urandom);
    endcase
  endfunction

  // put mean and copy near opposite ends of one axis
  function automatic void far_pair(output logic [CoordW-1:0] m, output logic [CoordW-1:0] p);
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    lo = CoordMin + CoordW'($urandom_range(255));
    hi = CoordMax - CoordW'($urandom_range(255));
    if ($urandom_range(1)) begin
      m = lo;
      p = hi;
    end else begin
      m = hi;
      p = lo;
    end
  endfunction

  function automatic restraint_item_t make_item(item_shape_e shape, logic last);
    restraint_item_t it;
    it.point = IdxW'($urandom);
    it.unit  = IdxW'($urandom);
    // mostly legal share counts; sometimes any code, to hit both clamps
    it.share = ($urandom_range(9) == 0) ? ShareW'($urandom) :
               ShareW'($urandom_range(MinShare, MaxShare));
    it.last  = last;
    case (shape)
      ShapeNear: begin
        it.mx = CoordW'($urandom);
        it.my = CoordW'($urandom);
        it.mz = CoordW'($urandom);
        it.px = nudged(it.mx);
        it.py = nudged(it.my);
        it.pz = nudged(it.mz);
      end
      ShapeCorner: begin
        it.mx = corner_coord();
        it.my = corner_coord();
        it.mz = corner_coord();
        it.px = corner_coord();
        it.py = corner_coord();
        it.pz = corner_coord();
      end
      ShapeFar: begin
        // anything at or above the top share count clamps to it
        it.share = ShareW'($urandom_range(MaxShare, 31));
        far_pair(it.mx, it.px);
        far_pair(it.my, it.py);
        far_pair(it.mz, it.pz);
      end
      default: begin
        it.mx = CoordW'($urandom);
        it.my = CoordW'($urandom);
        it.mz = CoordW'($urandom);
        it.px = CoordW'($urandom);
        it.py = CoordW'($urandom);
        it.pz = CoordW'($urandom);
      end
    endcase
    return it;
  endfunction

  // present one item from a falling edge and hold it until it is taken
  task automatic offer_item(restraint_item_t it);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    point_index      <= it.point;
    unit_point_index <= it.unit;
    share_count      <= it.share;
    mean_x           <= it.mx;
    mean_y           <= it.my;
    mean_z           <= it.mz;
    pos_x            <= it.px;
    pos_y            <= it.py;
    pos_z            <= it.pz;
    last_of_pass     <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // leaves the write enable high; the caller lowers it
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // reconfigure only once the block has gone idle
  task automatic load_config(logic [KW-1:0] k, logic [CutW-1:0] cut);
    drain_results();
    write_reg(CfgSpringK, CfgDataW'(k));
    write_reg(CfgCutoffSq, CfgDataW'(cut));
    cfg_we <= 1'b0;
  endtask

  // send whole passes of random length, each closed by a last item
  task automatic run_passes(int goal);
    int sent;
    int len;
    item_shape_e shape;
    sent = 0;
    while (sent < goal) begin
      len   = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30);
      shape = item_shape_e'($urandom_range(3));
      for (int i = 0; i < len; i++) begin
        // mix in a stray shape now and then
        offer_item(make_item(($urandom_range(3) == 0) ? item_shape_e'($urandom_range(3)) :
                             shape, i == len - 1));
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CfgSpringK;
    cfg_data         = '0;
    in_valid         = 1'b0;
    point_index      = '0;
    unit_point_index = '0;
    share_count      = '0;
    mean_x           = '0;
    mean_y           = '0;
    mean_z           = '0;
    pos_x            = '0;
    pos_y            = '0;
    pos_z            = '0;
    last_of_pass     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset settings: stiffness 10.0, cutoff 1.0.
    // zero share count clamps up to two; no distance at all
    offer_item(restraint_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // a distance of exactly the cutoff must not violate
    offer_item(restraint_item(5, 1, 1, 0, 0, 0, 24'd4096, 0, 0, 1'b0));
    // one step past it does; a share count above the top clamps down
    offer_item(restraint_item(6, 2, 17, 0, 0, 0, 24'd4097, 0, 0, 1'b0));
    // an equal distance later in the pass keeps the earlier worst point
    offer_item(restraint_item(7, 3, 31, 0, 0, 0, 0, 24'd4097, 0, 1'b0));
    // widest positive spread with all-ones indexes closes the pass
    offer_item(restraint_item('1, '1, 16, CoordMin, CoordMin, CoordMin,
                              CoordMax, CoordMax, CoordMax, 1'b1));
    // a pass of zero distances reports point zero
    offer_item(restraint_item(9, 4, 2, 24'd100, 24'd200, 24'd300,
                              24'd100, 24'd200, 24'd300, 1'b0));
    offer_item(restraint_item(10, 5, 3, 0, 0, 0, 0, 0, 0, 1'b1));
    // widest negative spread as a pass of one item
    offer_item(restraint_item(11, 6, 16, CoordMax, CoordMax, CoordMax,
                              CoordMin, CoordMin, CoordMin, 1'b1));

    // top stiffness, zero cutoff: six maximal items overflow the energy range
    load_config('1, '0);
    repeat (6) offer_item(restraint_item(12, 7, 16, CoordMin, CoordMin, CoordMin,
                                         CoordMax, CoordMax, CoordMax, 1'b0));
    // zero distance against a zero cutoff does not violate
    offer_item(restraint_item(13, 8, 16, 0, 0, 0, 0, 0, 0, 1'b1));

    // stiffness of 1/256 with share two: gradient halves land on rounding ties
    load_config(16'd1, '1);
    offer_item(restraint_item(14, 9, 2, 0, 0, 0, 24'd64, -24'sd64, 24'd192, 1'b0));
    offer_item(restraint_item(15, 10, 2, 0, 0, 0, -24'sd192, 0, 0, 1'b1));

    // Random passes under a walk of settings, the extremes first.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_config(SpringKRst, CutoffSqRst);
        1: load_config('0, '0);
        2: load_config('1, '1);
        default: load_config(KW'($urandom >> $urandom_range(16)),
                             CutW'({$urandom, $urandom}) >> $urandom_range(CutW - 1));
      endcase
      // hold one whole phase free of idling on both sides
      calm = (ph == 4);
      run_passes(PhaseItems);
    end

    // one long pass of maximal distances at low stiffness pins the sum at its ceiling
    load_config(KW'($urandom_range(1, 255)), CutW'({$urandom, $urandom}));
    for (int i = 0; i < FloodItems; i++) offer_item(make_item(ShapeFar, i == FloodItems - 1));
    // the passes after it must start from clear sums
    run_passes(40);

    drain_results();
    // give a stray extra result time to show up
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
